// File: sv/scp_pkg.sv
package scp_pkg;

	localparam int MAX_BEAMS = 4096;
	localparam int ANGLE_FRAC_BITS = 16;
	localparam longint PI_Q30 = 64'd3373259426;
	localparam int PI_A = int'((PI_Q30 + (64'd1 << (29 - ANGLE_FRAC_BITS)))
		>> (30 - ANGLE_FRAC_BITS));
	localparam int TWO_PI_A = 2 * PI_A;
	localparam int HALF_PI_A = PI_A / 2;

	localparam int CORDIC_GAIN = 39797;
	localparam int CORDIC_STEPS = 16;
	localparam int COUNT_MAX = 8191;
	localparam int COORD_MAX = 65535;

	localparam int IN_W = 16;
	localparam int OUT_W = 48;
	localparam int CFG_W = 19;
	localparam int CFG_IDX_W = 3;
	localparam int COORD_W = 18;
	localparam int SUM_W = 31;
	localparam int CNT_W = 13;
	localparam int Z_W = 19;
	localparam int CX_W = 35;
	localparam int QUO_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_LOW = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_HIGH = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_POINTS = 3'd7;

	typedef logic signed [COORD_W-1:0] coord_t;

	function automatic logic signed [Z_W-1:0] atan_lut(input logic [3:0] i);
		logic signed [Z_W-1:0] v;
		case (i)
			4'd0: v = 19'sd51472;
			4'd1: v = 19'sd30386;
			4'd2: v = 19'sd16055;
			4'd3: v = 19'sd8150;
			4'd4: v = 19'sd4091;
			4'd5: v = 19'sd2047;
			4'd6: v = 19'sd1024;
			4'd7: v = 19'sd512;
			4'd8: v = 19'sd256;
			4'd9: v = 19'sd128;
			4'd10: v = 19'sd64;
			4'd11: v = 19'sd32;
			4'd12: v = 19'sd16;
			4'd13: v = 19'sd8;
			4'd14: v = 19'sd4;
			4'd15: v = 19'sd2;
			default: v = 19'sd0;
		endcase
		return v;
	endfunction

endpackage

// File: sv/scp_cordic.sv
module scp_cordic (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [scp_pkg::IN_W-1:0]         range_mm,
	input  logic signed [scp_pkg::Z_W-1:0]   z_in,
	input  logic                             flip,
	output logic                             done,
	output scp_pkg::coord_t                  x,
	output scp_pkg::coord_t                  y
);
	import scp_pkg::*;

	logic signed [CX_W-1:0] x_q, y_q, dx, dy;
	logic signed [Z_W-1:0] z_q;
	logic [3:0] i_q;
	logic busy_q, done_q, flip_q;
	logic signed [CX_W-1:0] xr, yr;
	logic signed [CX_W-17:0] xs, ys;

	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 4'd1;
				if (i_q == 4'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CX_W'($signed({1'b0, range_mm}) * $signed(18'(CORDIC_GAIN)));
			y_q <= '0;
			z_q <= z_in;
			flip_q <= flip;
		end else if (busy_q) begin
			if (!z_q[Z_W-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_lut(i_q);
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_lut(i_q);
			end
		end
	end

	assign xr = (x_q + CX_W'(32768)) >>> 16;
	assign yr = (y_q + CX_W'(32768)) >>> 16;

	always_comb begin
		xs = flip_q ? -xr[CX_W-17:0] : xr[CX_W-17:0];
		ys = flip_q ? -yr[CX_W-17:0] : yr[CX_W-17:0];
		if (xs > (CX_W-16)'(COORD_MAX)) x = COORD_W'(COORD_MAX);
		else if (xs < -(CX_W-16)'(COORD_MAX)) x = -COORD_W'(COORD_MAX);
		else x = xs[COORD_W-1:0];
		if (ys > (CX_W-16)'(COORD_MAX)) y = COORD_W'(COORD_MAX);
		else if (ys < -(CX_W-16)'(COORD_MAX)) y = -COORD_W'(COORD_MAX);
		else y = ys[COORD_W-1:0];
	end

	assign done = done_q;
endmodule

// File: sv/scp_div.sv
module scp_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [scp_pkg::SUM_W-1:0]   num,
	input  logic [scp_pkg::CNT_W-1:0]          den,
	output logic                               done,
	output logic signed [scp_pkg::QUO_W-1:0]   quo
);
	import scp_pkg::*;

	logic [SUM_W-1:0] n_q;
	logic [CNT_W-1:0] d_q, rem_q;
	logic [CNT_W:0] t;
	logic [4:0] cnt_q;
	logic busy_q, done_q, neg_q, qbit;

	assign t = {rem_q, n_q[SUM_W-1]};
	assign qbit = t >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num[SUM_W-1] ? -num : num;
			neg_q <= num[SUM_W-1];
			d_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? CNT_W'(t - {1'b0, d_q}) : t[CNT_W-1:0];
			n_q <= {n_q[SUM_W-2:0], qbit};
		end
	end

	assign quo = neg_q ? -n_q[QUO_W-1:0] : n_q[QUO_W-1:0];
	assign done = done_q;
endmodule

// File: sv/scan_point_clustering_unit.sv
// Channel  Dir  Transfer                 Payload
// s_*      in   s_tvalid & s_tready      tdata range_mm, tuser range_infinite, tlast last_in_scan
// m_*      out  m_tvalid & m_tready      tdata centroid x/y, landmark_index; tuser valid; tlast
// cfg_*    in   cfg_we                   cfg_index selects register, cfg_data value
// A skipped sample goes from transfer to ready via the post and output states; a valid one
// first passes angle reduction and the 16 CORDIC iterations. Judging a closed cluster follows,
// and an accepted landmark runs the serial divider for x and y; a final beam may judge twice.
// One item at a time: s_tready is high only while the sequencer is idle.
// A result waits in the output register; the sequencer stalls only if a second one is due.
// arst_n clears control state and restores register reset values.
module scan_point_clustering_unit #(
	parameter int MAX_BEAMS = scp_pkg::MAX_BEAMS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [scp_pkg::IN_W-1:0]          s_tdata,  // range_mm
	input  logic                              s_tuser,  // range_infinite
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [scp_pkg::OUT_W-1:0]         m_tdata,  // centroid_x, centroid_y, landmark_index
	output logic                              m_tuser,  // landmark_valid
	output logic                              m_tlast,
	input  logic                              cfg_we,
	input  logic [scp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [scp_pkg::CFG_W-1:0]         cfg_data
);
	import scp_pkg::*;

	localparam int BI_W = $clog2(MAX_BEAMS);
	localparam int ANG_W = BI_W + 19;

	localparam logic [3:0] S_IDLE = 4'd0, S_ANG = 4'd1, S_NORM = 4'd2, S_RED = 4'd3,
		S_FOLD = 4'd4, S_CORD = 4'd5, S_GAP1 = 4'd6, S_GAP2 = 4'd7, S_DEC = 4'd8,
		S_WID1 = 4'd9, S_WID2 = 4'd10, S_JUDGE = 4'd11, S_DIVX = 4'd12,
		S_DIVY = 4'd13, S_POST = 4'd14, S_OUT = 4'd15;

	logic signed [18:0] ang_start_q;
	logic [16:0] ang_step_q;
	logic [15:0] rlo_q, rhi_q, wlo_q, whi_q;
	logic [11:0] gap_q;
	logic [CNT_W-1:0] minp_q;
	logic [23:0] g2_q;
	logic [31:0] wlo2_q, whi2_q;

	logic [3:0] state_q;
	logic [15:0] r_q;
	logic last_q, got_q, from_gap_q;
	logic [BI_W-1:0] bi_q;
	logic [CNT_W-1:0] count_q;
	logic [11:0] lmc_q, lmi_q;
	coord_t fx_q, fy_q, px_q, py_q, cx_q, cy_q;
	logic signed [SUM_W-1:0] sx_q, sy_q;
	logic signed [ANG_W-1:0] ang_q;
	logic [ANG_W-1:0] a_q;
	logic [ANG_W:0] dv_q;
	logic [38:0] acc_q;
	logic signed [QUO_W-1:0] qx_q, qy_q;

	logic cstart_q, dstart_q, cdone, ddone, flip;
	logic signed [Z_W-1:0] z;
	logic signed [20:0] af, af2;
	coord_t cord_x, cord_y;
	logic signed [QUO_W-1:0] quo;
	logic signed [18:0] d;
	logic signed [SUM_W-1:0] dnum;
	logic [BI_W+16:0] bprod;
	logic out_load;

	logic m_tvalid_q, m_tuser_q, m_tlast_q;
	logic [OUT_W-1:0] m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ang_start_q <= '0;
			ang_step_q <= '0;
			rlo_q <= '0;
			rhi_q <= 16'hFFFF;
			gap_q <= 12'd100;
			wlo_q <= 16'd150;
			whi_q <= 16'd450;
			minp_q <= 13'd4;
			g2_q <= 24'd10000;
			wlo2_q <= 32'd22500;
			whi2_q <= 32'd202500;
		end else begin
			g2_q <= gap_q * gap_q;
			wlo2_q <= wlo_q * wlo_q;
			whi2_q <= whi_q * whi_q;
			if (cfg_we) begin
				case (cfg_index)
					REG_ANGLE_START: ang_start_q <= cfg_data;
					REG_ANGLE_STEP: ang_step_q <= cfg_data[16:0];
					REG_RANGE_LOW: rlo_q <= cfg_data[15:0];
					REG_RANGE_HIGH: rhi_q <= cfg_data[15:0];
					REG_GAP_LIMIT: gap_q <= cfg_data[11:0];
					REG_WIDTH_LOW: wlo_q <= cfg_data[15:0];
					REG_WIDTH_HIGH: whi_q <= cfg_data[15:0];
					REG_MIN_POINTS: minp_q <= cfg_data[12:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		af = $signed({1'b0, a_q[19:0]});
		if (af > 21'(PI_A)) af = af - 21'(TWO_PI_A);
		flip = 1'b0;
		af2 = af;
		if (af > 21'(HALF_PI_A)) begin
			af2 = af - 21'(PI_A);
			flip = 1'b1;
		end else if (af < -21'(HALF_PI_A)) begin
			af2 = af + 21'(PI_A);
			flip = 1'b1;
		end
		z = af2[Z_W-1:0];
	end

	scp_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cstart_q), .range_mm(r_q), .z_in(z),
		.flip(flip), .done(cdone), .x(cord_x), .y(cord_y)
	);

	assign dnum = (state_q == S_DIVY) ? sy_q : sx_q;

	scp_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart_q), .num(dnum), .den(count_q),
		.done(ddone), .quo(quo)
	);

	always_comb begin
		case (state_q)
			S_GAP1: d = 19'(cx_q) - 19'(px_q);
			S_GAP2: d = 19'(cy_q) - 19'(py_q);
			S_WID1: d = 19'(px_q) - 19'(fx_q);
			default: d = 19'(py_q) - 19'(fy_q);
		endcase
	end

	assign bprod = bi_q * ang_step_q;
	assign s_tready = state_q == S_IDLE;
	assign out_load = state_q == S_OUT && (last_q || got_q) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			bi_q <= '0;
			count_q <= '0;
			lmc_q <= '0;
			cstart_q <= 1'b0;
			dstart_q <= 1'b0;
			got_q <= 1'b0;
			last_q <= 1'b0;
			from_gap_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			cstart_q <= 1'b0;
			dstart_q <= 1'b0;
			m_tvalid_q <= out_load || (m_tvalid_q && !m_tready);
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						last_q <= s_tlast;
						got_q <= 1'b0;
						if (!s_tuser && s_tdata >= rlo_q && s_tdata <= rhi_q)
							state_q <= S_ANG;
						else
							state_q <= S_POST;
					end
				end
				S_ANG: state_q <= S_NORM;
				S_NORM: state_q <= S_RED;
				S_RED: begin
					if (dv_q == (ANG_W+1)'(TWO_PI_A)) begin
						state_q <= S_FOLD;
					end
				end
				S_FOLD: begin
					cstart_q <= 1'b1;
					state_q <= S_CORD;
				end
				S_CORD: if (cdone) state_q <= S_GAP1;
				S_GAP1: state_q <= S_GAP2;
				S_GAP2: state_q <= S_DEC;
				S_DEC: begin
					if (count_q == '0) begin
						count_q <= 13'd1;
						state_q <= S_POST;
					end else if (acc_q < 39'(g2_q)) begin
						if (count_q < CNT_W'(COUNT_MAX)) count_q <= count_q + 13'd1;
						state_q <= S_POST;
					end else begin
						from_gap_q <= 1'b1;
						state_q <= S_WID1;
					end
				end
				S_WID1: state_q <= S_WID2;
				S_WID2: state_q <= S_JUDGE;
				S_JUDGE: begin
					if (count_q >= minp_q && acc_q >= 39'(wlo2_q) && acc_q <= 39'(whi2_q)) begin
						got_q <= 1'b1;
						lmc_q <= lmc_q + 12'd1;
						dstart_q <= 1'b1;
						state_q <= S_DIVX;
					end else begin
						count_q <= from_gap_q ? 13'd1 : 13'd0;
						state_q <= from_gap_q ? S_POST : S_OUT;
					end
				end
				S_DIVX: begin
					if (ddone) begin
						dstart_q <= 1'b1;
						state_q <= S_DIVY;
					end
				end
				S_DIVY: begin
					if (ddone) begin
						count_q <= from_gap_q ? 13'd1 : 13'd0;
						state_q <= from_gap_q ? S_POST : S_OUT;
					end
				end
				S_POST: begin
					from_gap_q <= 1'b0;
					if (last_q && !got_q && count_q != '0) state_q <= S_WID1;
					else state_q <= S_OUT;
				end
				S_OUT: begin
					if (!(last_q || got_q) || !m_tvalid_q || m_tready) begin
						state_q <= S_IDLE;
						if (last_q) begin
							bi_q <= '0;
							count_q <= '0;
							lmc_q <= '0;
						end else begin
							bi_q <= (bi_q == BI_W'(MAX_BEAMS - 1)) ? '0 : bi_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (s_tvalid) r_q <= s_tdata;
			S_ANG: ang_q <= ANG_W'(ang_start_q) + $signed({2'b0, bprod});
			S_NORM: begin
				a_q <= ang_q[ANG_W-1] ? ang_q + ANG_W'(TWO_PI_A) : ang_q;
				dv_q <= (ANG_W+1)'(TWO_PI_A) << (ANG_W - 18);
			end
			S_RED: begin
				if ({1'b0, a_q} >= dv_q) a_q <= a_q - dv_q[ANG_W-1:0];
				dv_q <= dv_q >> 1;
			end
			S_CORD: if (cdone) begin
				cx_q <= cord_x;
				cy_q <= cord_y;
			end
			S_GAP1, S_WID1: acc_q <= 39'(38'(d * d));
			S_GAP2, S_WID2: acc_q <= acc_q + 39'(38'(d * d));
			S_DEC: begin
				if (count_q == '0) begin
					fx_q <= cx_q; fy_q <= cy_q; px_q <= cx_q; py_q <= cy_q;
					sx_q <= SUM_W'(cx_q); sy_q <= SUM_W'(cy_q);
				end else if (acc_q < 39'(g2_q)) begin
					px_q <= cx_q; py_q <= cy_q;
					if (count_q < CNT_W'(COUNT_MAX)) begin
						sx_q <= sx_q + SUM_W'(cx_q);
						sy_q <= sy_q + SUM_W'(cy_q);
					end
				end
			end
			S_JUDGE: begin
				lmi_q <= lmc_q;
				if (!(count_q >= minp_q && acc_q >= 39'(wlo2_q) && acc_q <= 39'(whi2_q))
					&& from_gap_q) begin
					fx_q <= cx_q; fy_q <= cy_q; px_q <= cx_q; py_q <= cy_q;
					sx_q <= SUM_W'(cx_q); sy_q <= SUM_W'(cy_q);
				end
			end
			S_DIVX: if (ddone) qx_q <= quo;
			S_DIVY: if (ddone) begin
				qy_q <= quo;
				if (from_gap_q) begin
					fx_q <= cx_q; fy_q <= cy_q; px_q <= cx_q; py_q <= cy_q;
					sx_q <= SUM_W'(cx_q); sy_q <= SUM_W'(cy_q);
				end
			end
			default: ;
		endcase
		if (out_load) begin
			m_tuser_q <= got_q;
			m_tlast_q <= last_q;
			m_tdata_q <= got_q ? {2'b0, lmi_q, qy_q, qx_q} : '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;
	assign m_tlast = m_tlast_q;

	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0) else $error("payload not cleared");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(COUNT_MAX)) else $error("point count overrun");
	a_cordic_done: assert property (@(posedge clk) disable iff (!arst_n)
		cdone |-> state_q == S_CORD) else $error("stray cordic completion");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		ddone |-> state_q == S_DIVX || state_q == S_DIVY) else $error("stray divide");
endmodule

// File: bench/tb_scan_point_clustering_unit.sv
`timescale 1ns / 1ps

module tb_scan_point_clustering_unit;
	import scp_pkg::*;

	localparam int BEAMS = MAX_BEAMS;
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 200;

	typedef struct packed {
		logic        found;
		logic [16:0] cx;
		logic [16:0] cy;
		logic [11:0] idx;
		logic        done;
	} landmark_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;  // range_mm
	logic s_tuser = 1'b0;           // range_infinite
	logic s_tlast = 1'b0;           // last_in_scan
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;      // centroid_x, centroid_y, landmark_index
	logic m_tuser;                  // landmark_valid
	logic m_tlast;                  // scan_done
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	int failures = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	bit sink_active = 1'b0;
	landmark_t expected_landmarks[$];

	// predictor copy of registers and state
	longint p_astart, p_astep, p_rlow, p_rhigh, p_gap, p_wlow, p_whigh, p_minpts;
	int unsigned p_beam, p_count, p_lmk;
	longint p_fx, p_fy, p_px, p_py, p_sx, p_sy;

	scan_point_clustering_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic longint fshr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clamp_mm(longint v);
		if (v > COORD_MAX) return COORD_MAX;
		if (v < -COORD_MAX) return -COORD_MAX;
		return v;
	endfunction

	function automatic longint arctan_step(int i);
		longint tab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2};
		return tab[i];
	endfunction

	task automatic polar_to_xy(input longint r, input longint ang,
			output longint ox, output longint oy);
		longint pi, two_pi, half, a, z, x, y, dx, dy;
		bit flip;
		pi = (64'd3373259426 + (64'd1 << (29 - ANGLE_FRAC_BITS))) >> (30 - ANGLE_FRAC_BITS);
		two_pi = 2 * pi;
		half = pi / 2;
		flip = 1'b0;
		a = ang % two_pi;
		if (a < 0) a += two_pi;
		if (a > pi) a -= two_pi;
		if (a > half) begin
			a -= pi;
			flip = 1'b1;
		end else if (a < -half) begin
			a += pi;
			flip = 1'b1;
		end
		z = a;
		x = r * CORDIC_GAIN;
		y = 0;
		for (int i = 0; i < 16; i++) begin
			dx = fshr(y, i);
			dy = fshr(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= arctan_step(i);
			end else begin
				x += dx; y -= dy; z += arctan_step(i);
			end
		end
		x = fshr(x + 32768, 16);
		y = fshr(y + 32768, 16);
		if (flip) begin
			x = -x; y = -y;
		end
		ox = clamp_mm(x);
		oy = clamp_mm(y);
	endtask

	function automatic void begin_cluster(longint x, longint y);
		p_fx = x; p_px = x; p_sx = x;
		p_fy = y; p_py = y; p_sy = y;
		p_count = 1;
	endfunction

	function automatic bit judge_cluster(output longint cx, output longint cy,
			output int unsigned idx);
		longint dx, dy, w2;
		bit ok;
		cx = 0; cy = 0; idx = 0;
		if (p_count == 0) return 1'b0;
		dx = p_px - p_fx;
		dy = p_py - p_fy;
		w2 = dx * dx + dy * dy;
		ok = (p_count >= p_minpts) && w2 >= p_wlow * p_wlow && w2 <= p_whigh * p_whigh;
		if (ok) begin
			cx = p_sx / longint'(p_count);
			cy = p_sy / longint'(p_count);
			idx = p_lmk;
			p_lmk = (p_lmk + 1) & 12'hFFF;
		end
		p_count = 0;
		return ok;
	endfunction

	task automatic predict_beam(input logic [15:0] r, input bit inf, input bit last);
		bit got;
		longint cx, cy, x, y, dx, dy, st;
		int unsigned idx;
		landmark_t res;
		got = 1'b0; cx = 0; cy = 0; idx = 0;
		if (!inf && r >= p_rlow && r <= p_rhigh) begin
			st = p_astart;
			if (st & 'h40000) st -= 'h80000;
			polar_to_xy(r, st + longint'(p_beam) * p_astep, x, y);
			if (p_count == 0) begin_cluster(x, y);
			else begin
				dx = x - p_px;
				dy = y - p_py;
				if (dx * dx + dy * dy < p_gap * p_gap) begin
					p_px = x; p_py = y;
					if (p_count < COUNT_MAX) begin
						p_sx += x; p_sy += y; p_count++;
					end
				end else begin
					got = judge_cluster(cx, cy, idx);
					begin_cluster(x, y);
				end
			end
		end
		if (last) begin
			if (got) p_count = 0;
			else got = judge_cluster(cx, cy, idx);
		end
		if (last || got) begin
			res.found = got;
			res.cx = got ? cx[16:0] : '0;
			res.cy = got ? cy[16:0] : '0;
			res.idx = got ? idx[11:0] : '0;
			res.done = last;
			expected_landmarks = {expected_landmarks, res};
		end
		if (last) begin
			p_beam = 0; p_count = 0; p_lmk = 0;
		end else p_beam = (p_beam + 1 >= BEAMS) ? 0 : p_beam + 1;
	endtask

	function automatic int short_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_W-1:0];
		@(posedge clk);
		case (idx)
			REG_ANGLE_START: p_astart = value & 'h7FFFF;
			REG_ANGLE_STEP: p_astep = value & 'h1FFFF;
			REG_RANGE_LOW: p_rlow = value & 'hFFFF;
			REG_RANGE_HIGH: p_rhigh = value & 'hFFFF;
			REG_GAP_LIMIT: p_gap = value & 'hFFF;
			REG_WIDTH_LOW: p_wlow = value & 'hFFFF;
			REG_WIDTH_HIGH: p_whigh = value & 'hFFFF;
			REG_MIN_POINTS: p_minpts = value & 'h1FFF;
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_landmarks.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input longint astart, input longint astep, input longint rlow,
			input longint rhigh, input longint gap, input longint wlow,
			input longint whigh, input longint minpts);
		wait_drained();
		write_reg(REG_ANGLE_START, astart);
		write_reg(REG_ANGLE_STEP, astep);
		write_reg(REG_RANGE_LOW, rlow);
		write_reg(REG_RANGE_HIGH, rhigh);
		write_reg(REG_GAP_LIMIT, gap);
		write_reg(REG_WIDTH_LOW, wlow);
		write_reg(REG_WIDTH_HIGH, whigh);
		write_reg(REG_MIN_POINTS, minpts);
		cfg_we <= 1'b0;
	endtask

	task automatic send_beam(input logic [15:0] r, input bit inf, input bit last,
			input bit gaps);
		int g;
		g = gaps ? short_gap() : 0;
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= r;
		s_tuser <= inf;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_beam(r, inf, last);
	endtask

	// near-constant range along a small arc gives a compact cluster
	task automatic send_scan(input int beams, input bit gaps);
		logic [15:0] base;
		int r;
		base = $urandom_range(300, 5000);
		for (int b = 0; b < beams; b++) begin
			r = base + $urandom_range(0, 20) - 10;
			if ($urandom_range(0, 6) == 0) base = $urandom_range(300, 5000);
			send_beam(r[15:0], $urandom_range(0, 9) == 0, b == beams - 1, gaps);
		end
	endtask

	task automatic test_directed();
		configure(0, 0, 0, 65535, 100, 150, 450, 4);
		send_beam(16'd0, 1'b0, 1'b0, 1'b0);
		send_beam(16'hFFFF, 1'b0, 1'b0, 1'b0);
		send_beam(16'd1000, 1'b1, 1'b0, 1'b0);
		send_beam(16'd1000, 1'b0, 1'b1, 1'b0);
		send_beam(16'd1000, 1'b1, 1'b1, 1'b0);
		configure(0, 200, 0, 65535, 400, 150, 450, 4);
		for (int b = 0; b < 6; b++) send_beam(16'd1000, b == 2, 1'b0, 1'b0);
		send_beam(16'd5000, 1'b0, 1'b1, 1'b0);
		configure(205888, 65536, 0, 65535, 4095, 0, 65535, 1);
		for (int b = 0; b < 5; b++) send_beam(16'hFFFF, 1'b0, b == 4, 1'b0);
		configure(-205888, 65536, 2000, 1000, 100, 150, 450, 0);
		send_beam(16'd1500, 1'b0, 1'b0, 1'b0);
		send_beam(16'd1500, 1'b0, 1'b1, 1'b0);
		configure(0, 0, 0, 65535, 0, 0, 0, 1);
		send_beam(16'd7, 1'b0, 1'b0, 1'b0);
		send_beam(16'd7, 1'b0, 1'b1, 1'b0);
	endtask

	task automatic test_random_scans();
		configure(0, 300, 100, 60000, 200, 10, 800, 2);
		repeat (12) send_scan($urandom_range(4, 20), 1'b1);
		wait_drained();
		configure($urandom_range(0, 'h7FFFF), $urandom_range(0, 65536), $urandom_range(0, 500),
			$urandom_range(30000, 65535), $urandom_range(50, 4095), $urandom_range(0, 200),
			$urandom_range(200, 65535), $urandom_range(1, 5));
		repeat (12) send_scan($urandom_range(4, 20), 1'b1);
		configure(0, 1, 0, 65535, 4095, 0, 65535, 4096);
		repeat (4) send_scan($urandom_range(4, 12), 1'b0);
	endtask

	task automatic test_noise();
		configure(0, 1000, 0, 65535, 300, 0, 2000, 1);
		for (int n = 0; n < 100; n++)
			send_beam(16'($urandom_range(0, 65535)), $urandom_range(0, 3) == 0,
				$urandom_range(0, 15) == 0, 1'b1);
		send_beam(16'd100, 1'b0, 1'b1, 1'b1);
	endtask

	task automatic test_long_run();
		repeat (6) send_scan($urandom_range(4, 20), 1'b1);
		wait_drained();
	endtask

	always @(posedge clk) begin
		if (sink_active) begin
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if ($urandom_range(0, 49) == 0) begin
				m_tready <= 1'b0;
				stall_left <= $urandom_range(20, 150);
			end else begin
				m_tready <= ($urandom_range(0, 9) == 0) ? 1'b0 : 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		landmark_t want;
		if (m_tvalid && m_tready) begin
			if (expected_landmarks.size() == 0) begin
				$error("unexpected transfer tdata=%h", m_tdata);
				failures++;
			end else begin
				want = expected_landmarks.pop_front();
				if (m_tuser !== want.found) begin
					$error("landmark_valid exp %0d got %0d", want.found, m_tuser); failures++;
				end
				if (m_tdata[16:0] !== want.cx) begin
					$error("centroid_x exp %h got %h", want.cx, m_tdata[16:0]); failures++;
				end
				if (m_tdata[33:17] !== want.cy) begin
					$error("centroid_y exp %h got %h", want.cy, m_tdata[33:17]); failures++;
				end
				if (m_tdata[45:34] !== want.idx) begin
					$error("landmark_index exp %0d got %0d", want.idx, m_tdata[45:34]);
					failures++;
				end
				if (m_tlast !== want.done) begin
					$error("scan_done exp %0d got %0d", want.done, m_tlast); failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("** scan_point_clustering_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		p_astart = 0; p_astep = 0; p_rlow = 0; p_rhigh = 65535;
		p_gap = 100; p_wlow = 150; p_whigh = 450; p_minpts = 4;
		p_beam = 0; p_count = 0; p_lmk = 0;
		p_fx = 0; p_fy = 0; p_px = 0; p_py = 0; p_sx = 0; p_sy = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		sink_active = 1'b1;
		test_directed();
		test_random_scans();
		test_noise();
		test_long_run();
		if (failures == 0 && expected_landmarks.size() == 0)
			$display("** scan_point_clustering_unit: PASSED **");
		else
			$display("** scan_point_clustering_unit: FAILED **");
		$finish;
	end

endmodule
